>>> hw/rtl/fx2t_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fx2t_pkg
// Shared types, constants and helpers of the 16.16 fixed-point to decimal
// text converter.
// ----------------------------------------------------------------------------
package fx2t_pkg;

  localparam int TEXT_LEN = 8;

  localparam logic [31:0] THR_100   = 32'd6553600;
  localparam logic [31:0] THR_10    = 32'd655360;
  localparam logic [31:0] ROUND_INT = 32'd32768;
  localparam logic [31:0] ROUND_ONE = 32'd3276;
  localparam logic [31:0] ROUND_TWO = 32'd327;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    FMT_INT,
    FMT_ONE,
    FMT_TWO
  } fmt_t;

  typedef struct packed {
    logic        neg;
    logic [15:0] ipart;
    logic [6:0]  frac;
    fmt_t        fmt;
    logic [7:0]  budget;
  } split_t;

  typedef struct packed {
    logic            neg;
    logic [4:0][3:0] digit;
    logic [2:0]      ndig;
    logic [3:0]      ftens;
    logic [3:0]      fones;
    fmt_t            fmt;
    logic [7:0]      budget;
  } dig_t;

  typedef struct packed {
    logic [TEXT_LEN-1:0][7:0] chars;
    logic [2:0]               count;
  } text_t;

  // One step of the shift-and-add-three binary to BCD conversion.
  function automatic logic [19:0] dabble_shift(input logic [19:0] bcd, input logic b);
    logic [19:0] adj;
    adj = bcd;
    for (int i = 0; i < 5; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[18:0], b};
  endfunction

endpackage

>>> hw/rtl/fx2t_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fx2t_round
// Three pipeline stages: magnitude, rounding, and split into integer part,
// format and scaled fraction.
// ----------------------------------------------------------------------------
module fx2t_round (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 in_valid,
  input  logic signed [31:0]   value,
  input  logic [7:0]           buffer_size,
  output logic                 split_valid,
  output fx2t_pkg::split_t     split
);
  import fx2t_pkg::*;

  logic        a_valid;
  logic        a_neg;
  logic [31:0] a_mag;
  logic [7:0]  a_budget;

  logic        b_valid;
  logic        b_neg;
  logic [31:0] b_rmag;
  logic [7:0]  b_budget;

  logic [31:0] a_mag_next;
  logic [7:0]  a_budget_next;
  logic [31:0] b_rmag_next;
  logic [6:0]  scale;
  logic [22:0] prod;
  split_t      split_next;

  always_comb begin
    a_mag_next    = value[31] ? (~value + 32'd1) : value;
    a_budget_next = (buffer_size == 8'd0) ? 8'd0 : buffer_size - 8'd1;
  end

  always_comb begin
    if (a_mag >= THR_100) begin
      b_rmag_next = a_mag + ROUND_INT;
    end else if (a_mag >= THR_10) begin
      b_rmag_next = a_mag + ROUND_ONE;
    end else begin
      b_rmag_next = a_mag + ROUND_TWO;
    end
  end

  always_comb begin
    split_next.neg    = b_neg;
    split_next.ipart  = b_rmag[31:16];
    split_next.budget = b_budget;
    if (b_rmag >= THR_100) begin
      split_next.fmt = FMT_INT;
      scale          = 7'd10;
    end else if (b_rmag >= THR_10) begin
      split_next.fmt = FMT_ONE;
      scale          = 7'd10;
    end else begin
      split_next.fmt = FMT_TWO;
      scale          = 7'd100;
    end
    prod            = 23'(b_rmag[15:0]) * 23'(scale);
    split_next.frac = prod[22:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      split_valid <= 1'b0;
    end else if (advance) begin
      a_valid     <= in_valid;
      b_valid     <= a_valid;
      split_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_neg    <= value[31];
      a_mag    <= a_mag_next;
      a_budget <= a_budget_next;
      b_neg    <= a_neg;
      b_rmag   <= b_rmag_next;
      b_budget <= a_budget;
      split    <= split_next;
    end
  end

endmodule

>>> hw/rtl/fx2t_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fx2t_digits
// Two pipeline stages that turn the integer part into decimal digits, eight
// conversion steps each, and split the fraction into its digits.
// ----------------------------------------------------------------------------
module fx2t_digits (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               split_valid,
  input  fx2t_pkg::split_t   split,
  output logic               dig_valid,
  output fx2t_pkg::dig_t     dig
);
  import fx2t_pkg::*;

  logic        h_valid;
  logic [19:0] h_bcd;
  split_t      h_split;

  logic [19:0] h_bcd_next;
  logic [19:0] bcd;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens10;
  dig_t        dig_next;

  always_comb begin
    h_bcd_next = 20'd0;
    for (int i = 15; i >= 8; i--) begin
      h_bcd_next = dabble_shift(h_bcd_next, split.ipart[i]);
    end
  end

  always_comb begin
    bcd = h_bcd;
    for (int i = 7; i >= 0; i--) begin
      bcd = dabble_shift(bcd, h_split.ipart[i]);
    end
    tens_prod = 15'(h_split.frac) * 15'd205;
    tens      = tens_prod[14:11];
    tens10    = 7'(tens) * 7'd10;

    dig_next.neg    = h_split.neg;
    dig_next.digit  = bcd;
    dig_next.ftens  = tens;
    dig_next.fones  = 4'(h_split.frac - tens10);
    dig_next.fmt    = h_split.fmt;
    dig_next.budget = h_split.budget;
    if (bcd[19:16] != 4'd0) begin
      dig_next.ndig = 3'd5;
    end else if (bcd[15:12] != 4'd0) begin
      dig_next.ndig = 3'd4;
    end else if (bcd[11:8] != 4'd0) begin
      dig_next.ndig = 3'd3;
    end else if (bcd[7:4] != 4'd0) begin
      dig_next.ndig = 3'd2;
    end else begin
      dig_next.ndig = 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid   <= 1'b0;
      dig_valid <= 1'b0;
    end else if (advance) begin
      h_valid   <= split_valid;
      dig_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      h_bcd   <= h_bcd_next;
      h_split <= split;
      dig     <= dig_next;
    end
  end

endmodule

>>> hw/rtl/fx2t_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fx2t_text
// Pipeline stage that lays the characters out in a buffer and cuts the
// character count to the budget.
// ----------------------------------------------------------------------------
module fx2t_text (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             dig_valid,
  input  fx2t_pkg::dig_t   dig,
  output logic             text_valid,
  output fx2t_pkg::text_t  text
);
  import fx2t_pkg::*;

  logic [TEXT_LEN-1:0][7:0] chars;
  logic [2:0]               pos;
  text_t                    text_next;

  always_comb begin
    chars = '0;
    pos   = 3'd0;
    if (dig.neg) begin
      chars[pos] = CHAR_MINUS;
      pos        = pos + 3'd1;
    end
    for (int k = 4; k >= 0; k--) begin
      if (3'(k) < dig.ndig) begin
        chars[pos] = CHAR_ZERO + {4'd0, dig.digit[k]};
        pos        = pos + 3'd1;
      end
    end
    if (dig.fmt != FMT_INT) begin
      chars[pos] = CHAR_DOT;
      pos        = pos + 3'd1;
      if (dig.fmt == FMT_TWO) begin
        chars[pos] = CHAR_ZERO + {4'd0, dig.ftens};
        pos        = pos + 3'd1;
      end
      chars[pos] = CHAR_ZERO + {4'd0, dig.fones};
      pos        = pos + 3'd1;
    end
    chars[pos] = CHAR_SPACE;
    pos        = pos + 3'd1;

    text_next.chars = chars;
    text_next.count = (dig.budget < {5'd0, pos}) ? dig.budget[2:0] : pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (advance) begin
      text_valid <= dig_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      text <= text_next;
    end
  end

endmodule

>>> hw/rtl/fx2t_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fx2t_serial
// Output register that sends one item's characters, one per cycle while
// char_ready is high, then the terminator, loading the next item as it leaves.
// ----------------------------------------------------------------------------
module fx2t_serial (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  input  fx2t_pkg::text_t  text,
  output logic             load,
  output logic             char_valid,
  input  logic             char_ready,
  output logic [7:0]       character,
  output logic             is_last
);
  import fx2t_pkg::*;

  logic                     full;
  logic [2:0]               idx;
  logic [2:0]               count;
  logic [TEXT_LEN-1:0][7:0] chars;

  assign char_valid = full;
  assign is_last    = (idx == count);
  assign character  = (idx < count) ? chars[idx] : CHAR_NUL;
  assign load       = text_valid && (!full || (char_ready && is_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= 3'd0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= 3'd0;
    end else if (full && char_ready) begin
      if (is_last) begin
        full <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars <= text.chars;
      count <= text.count;
    end
  end

endmodule

>>> hw/rtl/fixed_16_16_to_decimal_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_16_16_to_decimal_text
// Formats a signed 16.16 fixed-point value as rounded decimal ASCII text.
// ----------------------------------------------------------------------------
// The input channel (item_valid / item_ready) takes a signed 16.16 value and
// a buffer size. The output channel (char_valid / char_ready) returns the
// text one character per item: an optional minus sign, the integer part,
// a point with one or two fraction digits below 100, and a space, all cut
// to buffer_size - 1 characters, then a zero terminator with is_last high.
// An item passes six pipeline registers (magnitude, rounding, split, two
// digit conversion stages, text layout) and then loads the output register,
// where its first character becomes valid.
// The output register sends one character per cycle while char_ready is
// high, and an item gives between one and eight characters: its kept
// characters plus the terminator. The next item loads in the cycle its
// predecessor's terminator leaves, and the pipeline takes a new item every
// cycle while that register keeps up.
// Reset clears all valid bits; no item is in flight afterward. Once the
// output register is full and the layout stage has an item waiting, the whole
// pipeline holds its contents while char_ready is low, and item_ready falls.
// ----------------------------------------------------------------------------
module fixed_16_16_to_decimal_text (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic signed [31:0] value,
  input  logic [7:0]         buffer_size,
  output logic               char_valid,
  input  logic               char_ready,
  output logic [7:0]         character,
  output logic               is_last
);
  import fx2t_pkg::*;

  logic   advance;
  logic   load;
  logic   split_valid;
  split_t split;
  logic   dig_valid;
  dig_t   dig;
  logic   text_valid;
  text_t  text;

  assign advance    = !text_valid || load;
  assign item_ready = advance;

  fx2t_round u_round (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .in_valid    (item_valid),
    .value       (value),
    .buffer_size (buffer_size),
    .split_valid (split_valid),
    .split       (split)
  );

  fx2t_digits u_digits (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .split_valid (split_valid),
    .split       (split),
    .dig_valid   (dig_valid),
    .dig         (dig)
  );

  fx2t_text u_text (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .dig_valid  (dig_valid),
    .dig        (dig),
    .text_valid (text_valid),
    .text       (text)
  );

  fx2t_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text       (text),
    .load       (load),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .character  (character),
    .is_last    (is_last)
  );

  a_last_is_nul: assert property (@(posedge clk) disable iff (rst)
    char_valid && is_last |-> character == CHAR_NUL)
    else $error("terminator item carries a nonzero character");

  a_text_not_nul: assert property (@(posedge clk) disable iff (rst)
    char_valid && !is_last |-> character != CHAR_NUL)
    else $error("text item carries a zero character");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    text_valid && !advance |=> text_valid && $stable(text))
    else $error("layout stage lost or changed an item during a stall");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !char_valid |-> item_ready)
    else $error("input stalled while the output register is empty");

endmodule

>>> tb/fx2t_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fx2t_text_checker
// Watches both channels of the fixed-point to text converter. Each accepted
// item is formatted here into the characters it should produce. Every
// accepted character is compared with the oldest one still owed.
// ----------------------------------------------------------------------------
module fx2t_text_checker
  import fx2t_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic [31:0] value,
  input  logic [7:0]  buffer_size,
  input  logic        char_valid,
  input  logic        char_ready,
  input  logic [7:0]  character,
  input  logic        is_last,
  output int          mismatches,
  output int          chars_pending
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  text_char_t owed_chars[$];

  assign chars_pending = owed_chars.size();

  function automatic void format_fixed_text(input logic [31:0] raw, input logic [7:0] size);
    logic [7:0]  text [16];
    logic [3:0]  digs [10];
    logic [32:0] mag;
    logic [31:0] ipart;
    logic [31:0] frac;
    fmt_t        fmt;
    int          len;
    int          nd;
    int          budget;
    int          keep;
    len = 0;
    mag = raw[31] ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
    if (raw[31]) begin
      text[len] = CHAR_MINUS;
      len++;
    end
    if (mag >= {1'b0, THR_100}) begin
      mag = mag + ROUND_INT;
    end else if (mag >= {1'b0, THR_10}) begin
      mag = mag + ROUND_ONE;
    end else begin
      mag = mag + ROUND_TWO;
    end
    ipart = 32'(mag[32:16]);
    nd = 0;
    do begin
      digs[nd] = 4'(ipart % 10);
      ipart = ipart / 10;
      nd++;
    end while (ipart != 0);
    for (int i = nd - 1; i >= 0; i--) begin
      text[len] = CHAR_ZERO + 8'(digs[i]);
      len++;
    end
    if (mag >= {1'b0, THR_100}) begin
      fmt = FMT_INT;
    end else if (mag >= {1'b0, THR_10}) begin
      fmt = FMT_ONE;
    end else begin
      fmt = FMT_TWO;
    end
    if (fmt != FMT_INT) begin
      text[len] = CHAR_DOT;
      len++;
      frac = (32'(mag[15:0]) * ((fmt == FMT_TWO) ? 32'd100 : 32'd10)) >> 16;
      if (fmt == FMT_TWO) begin
        text[len] = CHAR_ZERO + 8'(frac / 10);
        len++;
      end
      text[len] = CHAR_ZERO + 8'(frac % 10);
      len++;
    end
    text[len] = CHAR_SPACE;
    len++;
    budget = (size == 8'd0) ? 0 : int'(size) - 1;
    keep = (budget < len) ? budget : len;
    for (int i = 0; i < keep; i++) begin
      owed_chars.push_back('{ch: text[i], last: 1'b0});
    end
    owed_chars.push_back('{ch: CHAR_NUL, last: 1'b1});
  endfunction

  always @(posedge clk) begin
    text_char_t owed;
    if (rst) begin
      mismatches = 0;
    end else begin
      if (item_valid && item_ready) begin
        format_fixed_text(value, buffer_size);
      end
      if (char_valid && char_ready) begin
        if (owed_chars.size() == 0) begin
          $display("%0t: character %h is_last %b arrived with nothing owed",
                   $time, character, is_last);
          mismatches++;
        end else begin
          owed = owed_chars.pop_front();
          if (character !== owed.ch) begin
            $display("%0t: character expected %h actual %h", $time, owed.ch, character);
            mismatches++;
          end
          if (is_last !== owed.last) begin
            $display("%0t: is_last expected %b actual %b", $time, owed.last, is_last);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

>>> tb/tb_fixed_16_16_to_decimal_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_16_16_to_decimal_text
// Drives directed and random fixed-point values with assorted buffer sizes
// into the converter while either channel may stall at random. The checker
// predicts the text of every item and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_fixed_16_16_to_decimal_text;
  import fx2t_pkg::*;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  logic signed [31:0] value;
  logic [7:0]         buffer_size;
  logic               char_valid;
  logic               char_ready = 1'b0;
  logic [7:0]         character;
  logic               is_last;
  logic               tx_throttle;
  logic               rx_throttle;
  int                 rx_stall = 0;
  int                 mismatches;
  int                 chars_pending;

  fixed_16_16_to_decimal_text i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .value       (value),
    .buffer_size (buffer_size),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .character   (character),
    .is_last     (is_last)
  );

  fx2t_text_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .value         (value),
    .buffer_size   (buffer_size),
    .char_valid    (char_valid),
    .char_ready    (char_ready),
    .character     (character),
    .is_last       (is_last),
    .mismatches    (mismatches),
    .chars_pending (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_fixed_16_16_to_decimal_text failed");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] mag;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3, 4: mag = $urandom_range(0, THR_10 - 1);
      5: mag = $urandom_range(THR_10, THR_100 - 1);
      6: mag = $urandom_range(THR_100, 32'h7FFF_FFFF);
      7, 8: begin
        case ($urandom_range(0, 2))
          0: mag = THR_10;
          1: mag = THR_100;
          default: mag = 32'($urandom_range(0, 99)) << 16;
        endcase
        mag = mag + $urandom_range(0, 8000) - 32'd4000;
        if (mag[31]) begin
          mag = '0;
        end
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: mag = '0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  function automatic logic [7:0] pick_size();
    if ($urandom_range(0, 4) < 2) begin
      return 8'($urandom_range(1, 8));
    end
    return 8'($urandom_range(9, 255));
  endfunction

  task automatic send_item(input logic [31:0] v, input logic [7:0] s);
    int gap;
    item_valid <= 1'b1;
    value <= v;
    buffer_size <= s;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    gap = (tx_throttle && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_text();
    item_valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      char_ready <= 1'b0;
      rx_stall <= 0;
    end else if (rx_stall != 0) begin
      char_ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (rx_throttle && $urandom_range(0, 3) == 0) begin
      char_ready <= 1'b0;
      rx_stall <= gap_len() - 1;
    end else begin
      char_ready <= 1'b1;
    end
  end

  initial begin
    int phase;
    rst <= 1'b1;
    item_valid <= 1'b0;
    value <= '0;
    buffer_size <= '0;
    tx_throttle <= 1'b1;
    rx_throttle <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_item(32'h0000_0000, 8'd255);
    send_item(32'h0000_0001, 8'd255);
    send_item(32'hFFFF_FFFF, 8'd255);
    send_item(32'h8000_0000, 8'd255);
    send_item(32'h7FFF_FFFF, 8'd255);
    send_item(THR_100, 8'd255);
    send_item(THR_100 - 1, 8'd20);
    send_item(THR_100 - 32'd3277, 8'd20);
    send_item(THR_10, 8'd20);
    send_item(THR_10 - 1, 8'd20);
    send_item(THR_10 - 32'd328, 8'd20);
    send_item(32'h0001_8000, 8'd20);
    send_item(-32'sd809042, 8'd20);
    send_item(32'h0005_0000, 8'd20);
    send_item(-32'sd131072, 8'd20);
    send_item(32'hFFFF_FFFF, 8'd1);
    send_item(32'h007B_0000, 8'd0);
    send_item(32'h8000_0000, 8'd2);
    send_item(32'h8000_0000, 8'd3);
    send_item(32'h8000_0000, 8'd7);
    send_item(32'h8000_0000, 8'd8);
    send_item(32'h0009_FFFF, 8'd128);
    drain_text();

    for (int n = 0; n < 390; n++) begin
      if (n % 60 == 0) begin
        phase = (n / 60) % 4;
        tx_throttle <= (phase == 0 || phase == 2);
        rx_throttle <= (phase == 0 || phase == 3);
      end
      if (n % 97 == 96) begin
        drain_text();
      end
      send_item(pick_value(), pick_size());
    end
    drain_text();
    repeat (30) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_fixed_16_16_to_decimal_text passed");
    end else begin
      $display("tb_fixed_16_16_to_decimal_text failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/fx2t_pkg.sv
hw/rtl/fx2t_round.sv
hw/rtl/fx2t_digits.sv
hw/rtl/fx2t_text.sv
hw/rtl/fx2t_serial.sv
hw/rtl/fixed_16_16_to_decimal_text.sv
tb/fx2t_text_checker.sv
tb/tb_fixed_16_16_to_decimal_text.sv
